>>> rtl/wbss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_pkg - shared types and constants
// Action codes, sequencer states and fixed field widths of the windowed
// bit set store.
// ----------------------------------------------------------------------------
package wbss_pkg;

  // fixed field widths
  localparam int ACT_W     = 3;
  localparam int IDX_W     = 32;
  localparam int IN_W      = 40;   // 35 payload bits padded to bytes
  localparam int OUT_W     = 16;
  localparam int OUT_CNT_W = 13;
  localparam int CNT_SAT   = 8191;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET   = 3'd0,
    ACT_RESET = 3'd1,
    ACT_TEST  = 3'd2,
    ACT_TAS   = 3'd3,
    ACT_CLEAR = 3'd4,
    ACT_COUNT = 3'd5
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DECIDE,
    S_CHECK,
    S_MOVE,
    S_FILL,
    S_RD,
    S_MOD,
    S_DONE
  } state_t;

endpackage

>>> rtl/wbss_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_mem - window word memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wbss_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/wbss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_div - bit index to word index divider
// Divide by WORD_BITS through a reciprocal multiply: the dividend is registered
// on start, then the quotient, then the remainder together with done.
// ----------------------------------------------------------------------------
module wbss_div #(
  parameter int WORD_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wbss_pkg::IDX_W-1:0]   dividend,
  output logic                         done,
  output logic [wbss_pkg::IDX_W-1:0]   quot,
  output logic [$clog2(WORD_BITS)-1:0] rem
);
  import wbss_pkg::*;

  localparam int BW = $clog2(WORD_BITS);
  localparam int MW = IDX_W + 1;    // reciprocal width
  localparam int PW = IDX_W + MW;   // product width
  // ceil(2^(IDX_W+BW) / WORD_BITS), exact for every IDX_W-bit dividend
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << (IDX_W + BW)) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam logic [BW-1:0] DIV_LO = BW'(WORD_BITS);

  logic [IDX_W-1:0] dvd_r;
  logic [IDX_W-1:0] quot_r, quot_nxt;
  logic [BW-1:0]    rem_r, rem_nxt;
  logic             mul_r;   // quotient due at the next edge
  logic             sub_r;   // remainder due at the next edge
  logic             done_r;
  logic [PW-1:0]    prod;

  assign prod     = PW'(dvd_r) * PW'(RECIP);
  assign quot_nxt = IDX_W'(prod >> (IDX_W + BW));
  // only the low bits matter: the remainder is below WORD_BITS
  assign rem_nxt  = dvd_r[BW-1:0] - BW'(quot_r[BW-1:0] * DIV_LO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start;
      sub_r  <= mul_r;
      done_r <= sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (mul_r) begin
      quot_r <= quot_nxt;
    end
    if (sub_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

>>> rtl/wbss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_ctrl - action sequencer
// Window bookkeeping, growth walk over the word memory, read-modify-write
// of the target word and the result register.
// ----------------------------------------------------------------------------
module wbss_ctrl #(
  parameter int WORD_BITS = 64,
  parameter int MAX_WORDS = 64,
  parameter int AW        = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wbss_pkg::IN_W-1:0]      in_tdata,
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wbss_pkg::OUT_W-1:0]     out_tdata,
  // divider
  output logic                           div_start,
  output logic [wbss_pkg::IDX_W-1:0]     div_dividend,
  input  logic                           div_done,
  input  logic [wbss_pkg::IDX_W-1:0]     div_quot,
  input  logic [$clog2(WORD_BITS)-1:0]   div_rem,
  // word memory
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [WORD_BITS-1:0]           mem_wdata,
  output logic                           mem_re,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [WORD_BITS-1:0]           mem_rdata
);
  import wbss_pkg::*;

  localparam int BW     = $clog2(WORD_BITS);
  localparam int UW     = $clog2(MAX_WORDS + 1);
  localparam int CW     = $clog2(MAX_WORDS * WORD_BITS + 1);
  localparam int CW_EXT = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;
  localparam int EW     = IDX_W + 1;

  state_t           state_r, state_nxt;
  act_t             act_r;
  logic [IDX_W-1:0] bw_r;       // word index of the requested bit
  logic [BW-1:0]    off_r;      // bit offset within that word
  logic [IDX_W-1:0] ws_r;       // first word of the window
  logic [UW-1:0]    wiu_r;      // words in use
  logic [EW-1:0]    end_r;      // one past the last window word
  logic [CW-1:0]    cnt_r;      // set bits in the store
  logic [EW-1:0]    add_r;      // words to add on growth
  logic             lo_r;
  logic             emp_r;
  logic [AW-1:0]    rel_r;
  logic [AW-1:0]    src_r;
  logic [AW-1:0]    dst_r;
  logic [UW-1:0]    mv_left_r;
  logic             pend_r;
  logic [AW-1:0]    fill_addr_r;
  logic [UW-1:0]    fill_left_r;
  logic             res_r;
  logic             ovf_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic             in_acc;
  logic             dec_lo, dec_hi, dec_in;
  logic [EW-1:0]    dec_add_lo, dec_add_hi;
  logic             fits;
  logic             old_bit;
  logic [WORD_BITS-1:0] mask;
  logic             out_load;
  logic [CW_EXT-1:0] cnt_ext;
  logic [OUT_CNT_W-1:0] cnt_out;

  assign in_acc = in_tvalid && in_tready;

  // window compares on the word index, one bit wider than the index
  assign dec_lo     = {1'b0, bw_r} < {1'b0, ws_r};
  assign dec_hi     = {1'b0, bw_r} >= end_r;
  assign dec_in     = (wiu_r != '0) && !dec_lo && !dec_hi;
  assign dec_add_lo = {1'b0, ws_r} - {1'b0, bw_r};
  assign dec_add_hi = {1'b0, bw_r} - end_r + EW'(1);
  assign fits       = add_r <= (EW'(MAX_WORDS) - EW'(wiu_r));

  assign mask    = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_r;
  assign old_bit = |(mem_rdata & mask);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign cnt_ext  = CW_EXT'(cnt_r);
  assign cnt_out  = (cnt_ext > CW_EXT'(CNT_SAT)) ? OUT_CNT_W'(CNT_SAT)
                                                 : cnt_ext[OUT_CNT_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (act_r)
          ACT_TEST, ACT_RESET: state_nxt = dec_in ? S_RD : S_DONE;
          ACT_SET, ACT_TAS:    state_nxt = dec_in ? S_RD : S_CHECK;
          default:             state_nxt = S_DONE;
        endcase
      end
      S_CHECK: begin
        if (!fits)          state_nxt = S_DONE;
        else if (emp_r)     state_nxt = S_FILL;
        else if (lo_r)      state_nxt = S_MOVE;
        else                state_nxt = S_FILL;
      end
      S_MOVE: begin
        if (mv_left_r == '0) state_nxt = S_FILL;
      end
      S_FILL: begin
        if (fill_left_r == UW'(1)) state_nxt = S_RD;
      end
      S_RD:   state_nxt = S_MOD;
      S_MOD:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs to the ports, divider and memory
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = dst_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = src_r;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_MOVE: begin
        mem_re = (mv_left_r != '0);
        mem_we = pend_r;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr_r;
        mem_wdata = '0;
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = rel_r;
      end
      S_MOD: begin
        mem_waddr = rel_r;
        unique case (act_r)
          ACT_RESET: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~mask;
          end
          ACT_SET, ACT_TAS: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | mask;
          end
          default: mem_we = 1'b0;
        endcase
      end
      default: in_tready = 1'b0;
    endcase
  end

  assign div_start    = in_acc;
  assign div_dividend = in_tdata[ACT_W +: IDX_W];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= '0;
      wiu_r       <= '0;
      end_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_DECIDE: begin
          if (act_r == ACT_CLEAR) begin
            ws_r  <= '0;
            wiu_r <= '0;
            end_r <= '0;
            cnt_r <= '0;
          end
        end
        S_CHECK: begin
          pend_r <= 1'b0;
          if (fits) begin
            wiu_r <= wiu_r + add_r[UW-1:0];
            if (emp_r || lo_r) ws_r <= bw_r;
            if (emp_r || !lo_r) end_r <= {1'b0, bw_r} + EW'(1);
          end
        end
        S_MOVE: pend_r <= (mv_left_r != '0);
        S_MOD: begin
          unique case (act_r)
            ACT_RESET: if (old_bit) cnt_r <= cnt_r - CW'(1);
            ACT_SET, ACT_TAS: if (!old_bit) cnt_r <= cnt_r + CW'(1);
            default: cnt_r <= cnt_r;
          endcase
        end
        default: pend_r <= pend_r;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= act_t'(in_tdata[ACT_W-1:0]);
    end
    if (out_load) begin
      out_data_r <= {ovf_r, (cnt_r == '0), cnt_out, res_r};
    end
    unique case (state_r)
      S_DIV: begin
        bw_r  <= div_quot;
        off_r <= div_rem;
      end
      S_DECIDE: begin
        res_r <= 1'b0;
        ovf_r <= 1'b0;
        lo_r  <= dec_lo;
        emp_r <= (wiu_r == '0);
        rel_r <= AW'(bw_r - ws_r);
        if (wiu_r == '0) add_r <= EW'(1);
        else if (dec_lo) add_r <= dec_add_lo;
        else add_r <= dec_add_hi;
      end
      S_CHECK: begin
        if (!fits) ovf_r <= 1'b1;
        if (emp_r || lo_r) rel_r <= '0;
        src_r     <= AW'(wiu_r - UW'(1));
        mv_left_r <= wiu_r;
        if (emp_r || lo_r) fill_addr_r <= '0;
        else fill_addr_r <= AW'(wiu_r);
        fill_left_r <= add_r[UW-1:0];
      end
      S_MOVE: begin
        if (mv_left_r != '0) begin
          dst_r     <= src_r + add_r[AW-1:0];
          src_r     <= src_r - AW'(1);
          mv_left_r <= mv_left_r - UW'(1);
        end
      end
      S_FILL: begin
        fill_addr_r <= fill_addr_r + AW'(1);
        fill_left_r <= fill_left_r - UW'(1);
      end
      S_MOD: begin
        if (act_r == ACT_TEST) res_r <= old_bit;
        else if (act_r == ACT_TAS) res_r <= !old_bit;
      end
      default: res_r <= res_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // window never exceeds capacity
  a_wiu_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wiu_r <= UW'(MAX_WORDS))
    else $error("window larger than capacity");

  // end pointer tracks start plus size
  a_end_trk: assert property (@(posedge clk) disable iff (!rst_n)
    end_r == ({1'b0, ws_r} + EW'(wiu_r)))
    else $error("window end out of step");

  // an empty window holds no set bits
  a_emp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wiu_r == '0) |-> (cnt_r == '0))
    else $error("set bits without a window");

  // growth only ever follows a set or a set-if-clear
  a_grow_act: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (act_r == ACT_SET || act_r == ACT_TAS))
    else $error("growth on wrong action");

endmodule

>>> rtl/windowed_bit_set_store.sv
`timescale 1ns / 1ps
// Sequence: a request on a window word passes the divider, decide, read, modify
//   and result load; clear, count and misses go from decide to the result load.
// Growth adds a check and a zero fill of the added words above the window; below
//   it the words in use are first moved up one per cycle. An overflowing set ends at the check.
// One request at a time: the next is taken from the cycle after the result loads
//   into the output register. Reset empties the window but does not clear the word memory.
// ----------------------------------------------------------------------------
// windowed_bit_set_store - offset window bit vector
// Bit set held as a window of words starting at a word-aligned position,
// growing on set at either end up to MAX_WORDS words.
// ----------------------------------------------------------------------------
module windowed_bit_set_store #(
  parameter int WORD_BITS = 64,  // 8..64
  parameter int MAX_WORDS = 64   // 1..4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] action, [34:3] bit_index, [39:35] zero
  input  logic [wbss_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] bit_result, [13:1] ones_count, [14] is_empty, [15] overflow
  output logic [wbss_pkg::OUT_W-1:0]    out_tdata
);
  import wbss_pkg::*;

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);

  // divider link: bit index in, word index and bit offset out
  logic             div_start;
  logic [IDX_W-1:0] div_dividend;
  logic             div_done;
  logic [IDX_W-1:0] div_quot;
  logic [BW-1:0]    div_rem;

  // memory port
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Divide unit: bit index -> (word index, offset) by reciprocal multiply,
  // quotient registered first, then the remainder.
  wbss_div #(
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Window words, entry 0 is the first word of the window.
  wbss_mem #(
    .DEPTH (MAX_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: bounds check, growth walk (move up for prepend, zero fill),
  // read-modify-write, running ones count and the result register.
  wbss_ctrl #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS),
    .AW        (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .div_rem      (div_rem),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - windowed bit set store check
// Sends set, reset, test, test-and-set, clear and count requests. A directed
// list covers the window edges, capacity limits and the top of the index
// range. Random requests then follow, mostly clustered around a moving base so
// that the window grows in earnest, with clears that empty it. A scoreboard keeps its own
// copy of the window and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import wbss_pkg::*;

  localparam int WORD_BITS = 64;
  localparam int MAX_WORDS = 64;
  localparam int N_RANDOM  = 950;
  localparam int HANG_LIMIT = 4000;   // cycles with no handshake on either side
  localparam int TAIL_CYCLES = 20;

  // codes outside act_t; the block treats them like count
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    logic                 overflow;
    logic                 is_empty;
    logic [OUT_CNT_W-1:0] ones_count;
    logic                 bit_result;
  } status_t;

  // Keeps its own copy of the window and the queue of statuses still due.
  class bitset_scoreboard;
    longint unsigned      win_start;
    int unsigned          win_words;
    logic [WORD_BITS-1:0] words [MAX_WORDS];
    status_t              due_q [$];
    int                   errors;

    function new();
      win_start = 0;
      win_words = 0;
      errors    = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    // full-precision bounds: the window end may reach 2^32
    function bit holds(longint unsigned b);
      return win_words != 0 && b >= win_start &&
             b < win_start + longint'(win_words) * WORD_BITS;
    endfunction

    function bit read_bit(longint unsigned b);
      if (!holds(b)) return 1'b0;
      return words[int'((b - win_start) / WORD_BITS)][int'(b % WORD_BITS)];
    endfunction

    // returns 0 when growth would pass capacity; nothing changes then
    function bit grow_and_set(longint unsigned b);
      longint unsigned aligned;
      longint unsigned add;
      aligned = (b / WORD_BITS) * WORD_BITS;
      if (win_words == 0) begin
        win_start = aligned;
        words[0]  = '0;
        win_words = 1;
      end else if (b < win_start) begin
        add = (win_start - aligned) / WORD_BITS;
        if (win_words + add > MAX_WORDS) return 1'b0;
        for (int i = int'(win_words) - 1; i >= 0; i--) words[i + int'(add)] = words[i];
        for (int i = 0; i < int'(add); i++) words[i] = '0;
        win_words += int'(add);
        win_start = aligned;
      end else if (!holds(b)) begin
        add = b / WORD_BITS - (win_start / WORD_BITS + win_words) + 1;
        if (win_words + add > MAX_WORDS) return 1'b0;
        for (int i = 0; i < int'(add); i++) words[int'(win_words) + i] = '0;
        win_words += int'(add);
      end
      words[int'((b - win_start) / WORD_BITS)][int'(b % WORD_BITS)] = 1'b1;
      return 1'b1;
    endfunction

    function void note_request(logic [IN_W-1:0] req);
      logic [ACT_W-1:0] act;
      longint unsigned  b;
      status_t          st;
      int unsigned      n;
      act = req[ACT_W-1:0];
      b   = longint'(req[ACT_W +: IDX_W]);
      st  = '0;
      n   = 0;
      case (act)
        ACT_SET: st.overflow = !grow_and_set(b);
        ACT_RESET: begin
          if (holds(b)) words[int'((b - win_start) / WORD_BITS)][int'(b % WORD_BITS)] = 1'b0;
        end
        ACT_TEST: st.bit_result = read_bit(b);
        ACT_TAS: begin
          if (!read_bit(b)) begin
            if (grow_and_set(b)) st.bit_result = 1'b1;
            else st.overflow = 1'b1;
          end
        end
        ACT_CLEAR: begin
          win_start = 0;
          win_words = 0;
        end
        default: ;  // count and spare codes leave the store alone
      endcase
      for (int i = 0; i < int'(win_words); i++) n += $countones(words[i]);
      if (n > CNT_SAT) n = CNT_SAT;
      st.ones_count = n[OUT_CNT_W-1:0];
      st.is_empty   = (n == 0);
      due_q = {due_q, st};
    endfunction

    function void check_result(logic [OUT_W-1:0] rsp);
      status_t got;
      status_t exp;
      got = rsp;
      if (due_q.size() == 0) begin
        $error("result with no request pending: %h", rsp);
        errors++;
        return;
      end
      exp = due_q.pop_front();
      if (got.bit_result !== exp.bit_result) begin
        $error("bit_result: expected %0d, actual %0d", exp.bit_result, got.bit_result);
        errors++;
      end
      if (got.ones_count !== exp.ones_count) begin
        $error("ones_count: expected %0d, actual %0d", exp.ones_count, got.ones_count);
        errors++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $error("is_empty: expected %0d, actual %0d", exp.is_empty, got.is_empty);
        errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $error("overflow: expected %0d, actual %0d", exp.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // [2:0] action, [34:3] bit_index, [39:35] zero
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // [0] bit_result, [13:1] ones_count, [14] is_empty,
                                     // [15] overflow

  int               idle_pct = 28;   // dropped to zero for a quiet stretch
  int               hang_cnt = 0;
  bitset_scoreboard sb = new();

  windowed_bit_set_store #(
    .WORD_BITS(WORD_BITS),
    .MAX_WORDS(MAX_WORDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Single reset pulse at the start.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Result side: random back-pressure, none during the quiet stretch.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Both monitors see pre-edge values, so NBA updates at this edge never race them.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog: any stretch without a handshake on either side past the limit is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  // Presents one request and returns at the edge that accepts it. tvalid is only
  // lowered while idling, so back-to-back requests never see it toggle in one step.
  task automatic send_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - ACT_W - IDX_W){1'b0}}, idx, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] idx;
    logic [ACT_W-1:0] act;
    int               pick;

    while (!rst_n) @(posedge clk);
    @(posedge clk);

    // --- directed ---
    send_request(ACT_COUNT, 32'h0000_1234);   // empty store
    send_request(ACT_TEST, 32'd5);            // test on empty reads zero
    send_request(ACT_RESET, 32'd5);           // reset on empty: no change
    send_request(ACT_SET, 32'd100);           // first set places window at word 1
    send_request(ACT_TEST, 32'd100);
    send_request(ACT_TAS, 32'd100);           // already set -> 0
    send_request(ACT_TAS, 32'd101);           // newly set -> 1
    send_request(ACT_TEST, 32'd200);          // above window reads zero
    send_request(ACT_RESET, 32'd50);          // below window: no change
    send_request(ACT_SET, 32'd10);            // prepend one word
    send_request(ACT_SET, 32'd700);           // append words
    send_request(ACT_RESET, 32'd100);
    send_request(ACT_SET, 32'h8000_0000);     // growth past capacity
    send_request(ACT_TAS, 32'hFFFF_FFFF);     // test-and-set overflow gives 0
    send_request(ACT_CLEAR, 32'hFFFF_FFFF);
    send_request(ACT_SET, 32'hFFFF_FFFF);     // window end reaches 2^32
    send_request(ACT_TEST, 32'hFFFF_FFFF);
    send_request(ACT_SET, 32'hFFFF_F000);     // fills exactly MAX_WORDS words
    send_request(ACT_SET, 32'hFFFF_EFFF);     // one word too many below
    send_request(ACT_TEST, 32'd0);
    send_request(ACT_SPARE6, 32'hFFFF_FFC0);
    send_request(ACT_SPARE7, 32'd0);
    send_request(ACT_CLEAR, 32'd0);
    send_request(ACT_SET, 32'd0);
    send_request(ACT_TEST, 32'd0);

    // --- random: clustered around a base, with some scattered noise ---
    base = 32'd3000;
    for (int k = 0; k < N_RANDOM; k++) begin
      idle_pct = (k >= 400 && k < 550) ? 0 : 28;
      if ($urandom_range(99) < 2) begin
        case ($urandom_range(3))
          0: base = 32'd3000;
          1: base = 32'hFFFF_FFFF - 32'd3000;
          default: base = $urandom_range(32'hFFFF_F447, 3000);
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 30)      act = ACT_SET;
      else if (pick < 45) act = ACT_TAS;
      else if (pick < 65) act = ACT_TEST;
      else if (pick < 80) act = ACT_RESET;
      else if (pick < 85) act = ACT_COUNT;
      else if (pick < 88) act = ACT_CLEAR;
      else if (pick < 90) act = ($urandom_range(1) != 0) ? ACT_SPARE7 : ACT_SPARE6;
      else                act = ACT_SET;
      if ($urandom_range(99) < 85) idx = base + $urandom_range(5000) - 32'd2500;
      else                         idx = $urandom;
      send_request(act, idx);
    end
    idle_pct = 28;
    in_tvalid <= 1'b0;

    // drain, then a short tail to catch stray results
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
